// ===== src/knn_pkg.sv =====
// Package with the types, constants and helpers shared by the kNN classifier.
package knn_pkg;

  // Default sizes of the block.
  localparam int MaxTrainDefault   = 1024;
  localparam int RowMaxDefault     = 1024;
  localparam int MaxKDefault       = 16;
  localparam int NumClassesDefault = 10;

  // Fixed field widths.
  localparam int PixelW = 8;
  localparam int LabelW = 4;
  localparam int DistW  = 24;
  localparam int KW     = 5;
  localparam int LenW   = 11;
  localparam int RootW  = 32;
  localparam int RadW   = 64;

  // Configuration register indexes.
  localparam logic [1:0] RegNeighborCount = 2'd0;
  localparam logic [1:0] RegWeightedVote  = 2'd1;
  localparam logic [1:0] RegRowLength     = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [KW-1:0]   NeighborCountReset = 5'd1;
  localparam logic [LenW-1:0] RowLengthReset     = 11'd784;

  // Controller states.
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_ROW_START,
    ST_ACCUM,
    ST_ACCUM_TAIL,
    ST_SQRT,
    ST_INSERT,
    ST_SETTLE,
    ST_VOTE_CLEAR,
    ST_VOTE_TALLY,
    ST_VOTE_PICK,
    ST_EMIT
  } state_t;

endpackage

// ===== src/knn_digit_classifier.sv =====
// Top level of the k-nearest-neighbor digit classifier.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------------
//   in      | input     | in_valid / in_stall  | req_type, pixel, train_label
//   out     | output    | out_valid / out_stall| predicted_label
//   cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A pixel that does not end a query row is only stored. The last pixel of a
// query starts a pass over all stored rows: each row of row_length pixels is
// read through the single pixel memory port, then goes through the square root,
// an insert step and list settling. A last row check and the vote then follow,
// ending with the emit.
// Reset is synchronous; the input is stalled for the whole search, and a
// result still waiting on out_stall holds back the next emit.
module knn_digit_classifier #(
  parameter int MaxTrain   = knn_pkg::MaxTrainDefault,
  parameter int RowMax     = knn_pkg::RowMaxDefault,
  parameter int MaxK       = knn_pkg::MaxKDefault,
  parameter int NumClasses = knn_pkg::NumClassesDefault
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        req_type,
  input  logic [knn_pkg::PixelW-1:0]  pixel,
  input  logic [knn_pkg::LabelW-1:0]  train_label,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [knn_pkg::LabelW-1:0]  predicted_label,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [31:0]                 cfg_data
);

  localparam int PosW   = (RowMax > 1) ? $clog2(RowMax) : 1;
  localparam int RowW   = (MaxTrain > 1) ? $clog2(MaxTrain) : 1;
  localparam int CntW   = $clog2(MaxTrain + 1);
  localparam int PixAW  = RowW + PosW;
  // Memory depths cover the full address space of the row and position fields.
  localparam int PixD   = 1 << PixAW;
  localparam int LabD   = 1 << RowW;
  localparam int QryD   = 1 << PosW;
  localparam int KIdxW  = (MaxK > 1) ? $clog2(MaxK) : 1;
  localparam int FillW  = $clog2(MaxK + 1);
  localparam int ClsW   = (NumClasses > 1) ? $clog2(NumClasses) : 1;
  localparam int SumW   = 2 * knn_pkg::PixelW + PosW + 1;
  localparam int MsumW  = knn_pkg::DistW + FillW;
  localparam int LenMW  = $clog2(RowMax + 1);

  // Configuration registers.
  logic [knn_pkg::KW-1:0]   neighbor_count;
  logic                     weighted_vote;
  logic [knn_pkg::LenW-1:0] row_length;

  // Control and data registers.
  knn_pkg::state_t state, state_next;
  logic [CntW-1:0]  stored_rows;
  logic [PosW-1:0]  pixel_position;
  logic [CntW-1:0]  row;
  logic [LenMW-1:0] acc_pos;
  logic [SumW-1:0]  sq_sum;
  logic [knn_pkg::RadW-1:0]  rad;
  logic [knn_pkg::RootW-1:0] root;
  logic [knn_pkg::RadW-1:0]  rem_r;
  logic [5:0]                sq_step;
  logic [knn_pkg::DistW-1:0] cur_dist;
  logic [knn_pkg::LabelW-1:0] cur_label;
  logic [knn_pkg::DistW-1:0] nd [MaxK];
  logic [knn_pkg::LabelW-1:0] nl [MaxK];
  logic [FillW-1:0] nearest_filled;
  logic [FillW-1:0] sj;
  logic [FillW-1:0] vi;
  logic [FillW-1:0] cnt [NumClasses];
  logic [MsumW-1:0] msum [NumClasses];
  logic [ClsW-1:0]  vc;
  logic [ClsW-1:0]  best;
  logic             found;
  logic [knn_pkg::LabelW-1:0] result;
  logic             out_full;

  // Effective configuration values.
  logic [LenMW-1:0] eff_len;
  logic [FillW-1:0] eff_k;
  always_comb begin
    if (row_length == '0) begin
      eff_len = LenMW'(1);
    end else if (32'(row_length) > RowMax) begin
      eff_len = LenMW'(RowMax);
    end else begin
      eff_len = LenMW'(row_length);
    end
    if (neighbor_count == '0) begin
      eff_k = FillW'(1);
    end else if (32'(neighbor_count) > MaxK) begin
      eff_k = FillW'(MaxK);
    end else begin
      eff_k = FillW'(neighbor_count);
    end
  end

  // Input transfer decode.
  logic in_xfer;
  logic last_pix;
  logic store_ok;
  logic [knn_pkg::LabelW-1:0] lab_sat;
  assign in_stall = (state != knn_pkg::ST_LOAD);
  assign in_xfer  = in_valid && !in_stall;
  assign last_pix = (32'(pixel_position) + 1 >= 32'(eff_len));
  assign store_ok = (32'(stored_rows) < MaxTrain);
  assign lab_sat  = (32'(train_label) >= NumClasses) ?
                    knn_pkg::LabelW'(NumClasses - 1) : train_label;

  // Memories: training pixels, training labels and the query row.
  logic                      pix_we, lab_we, q_we;
  logic [PixAW-1:0]          pix_waddr, pix_raddr;
  logic [knn_pkg::PixelW-1:0] pix_rdata, q_rdata;
  logic [knn_pkg::LabelW-1:0] lab_rdata;
  logic [PosW-1:0]           rd_pos;
  logic [RowW-1:0]           row_idx, st_idx;

  assign row_idx   = row[RowW-1:0];
  assign st_idx    = stored_rows[RowW-1:0];
  assign rd_pos    = acc_pos[PosW-1:0];
  assign pix_we    = in_xfer && !req_type && store_ok;
  assign lab_we    = pix_we && last_pix;
  assign q_we      = in_xfer && req_type;
  assign pix_waddr = {st_idx, pixel_position};
  assign pix_raddr = {row_idx, rd_pos};

  knn_ram #(.Width(knn_pkg::PixelW), .Depth(PixD)) u_pix_ram (
    .clk(clk), .we(pix_we), .waddr(pix_waddr), .wdata(pixel),
    .raddr(pix_raddr), .rdata(pix_rdata)
  );
  knn_ram #(.Width(knn_pkg::LabelW), .Depth(LabD)) u_lab_ram (
    .clk(clk), .we(lab_we), .waddr(st_idx), .wdata(lab_sat),
    .raddr(row_idx), .rdata(lab_rdata)
  );
  knn_ram #(.Width(knn_pkg::PixelW), .Depth(QryD)) u_query_ram (
    .clk(clk), .we(q_we), .waddr(pixel_position), .wdata(pixel),
    .raddr(rd_pos), .rdata(q_rdata)
  );

  // Squared difference of the pixel pair read last cycle.
  logic signed [knn_pkg::PixelW:0] diff;
  logic [2*knn_pkg::PixelW-1:0]    sqd;
  assign diff = $signed({1'b0, q_rdata}) - $signed({1'b0, pix_rdata});
  assign sqd  = (2*knn_pkg::PixelW)'(diff * diff);

  // One step of the bit-pair square root.
  logic [knn_pkg::RadW-1:0] trial;
  logic [knn_pkg::RadW-1:0] top2;
  logic [knn_pkg::RadW-1:0] rem_sh;
  assign top2   = rad >> (knn_pkg::RadW - 2);
  assign rem_sh = (rem_r << 2) | top2;
  assign trial  = {root, 2'b01};

  // Settle compare and vote compare.
  logic [FillW-1:0] sjm;
  logic [FillW-1:0] km;
  logic [KIdxW-1:0] sj_i, sjm_i, vi_i, km_i;
  logic [2*MsumW-1:0] lhs, rhs;
  assign sjm   = sj - FillW'(1);
  assign km    = eff_k - FillW'(1);
  assign sj_i  = sj[KIdxW-1:0];
  assign sjm_i = sjm[KIdxW-1:0];
  assign vi_i  = vi[KIdxW-1:0];
  assign km_i  = km[KIdxW-1:0];
  assign lhs   = msum[best] * cnt[vc];
  assign rhs   = msum[vc] * cnt[best];

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      knn_pkg::ST_LOAD: begin
        if (in_xfer && last_pix && req_type) begin
          state_next = knn_pkg::ST_ROW_START;
        end
      end
      knn_pkg::ST_ROW_START: begin
        if (32'(row) < 32'(stored_rows) && 32'(row) < MaxTrain) begin
          state_next = knn_pkg::ST_ACCUM;
        end else begin
          state_next = knn_pkg::ST_VOTE_CLEAR;
        end
      end
      knn_pkg::ST_ACCUM: begin
        if (acc_pos + LenMW'(1) >= eff_len) begin
          state_next = knn_pkg::ST_ACCUM_TAIL;
        end
      end
      knn_pkg::ST_ACCUM_TAIL: state_next = knn_pkg::ST_SQRT;
      knn_pkg::ST_SQRT: begin
        if (sq_step == 6'd31) begin
          state_next = knn_pkg::ST_INSERT;
        end
      end
      knn_pkg::ST_INSERT: begin
        if (nearest_filled < eff_k || nd[km_i] > cur_dist) begin
          state_next = knn_pkg::ST_SETTLE;
        end else begin
          state_next = knn_pkg::ST_ROW_START;
        end
      end
      knn_pkg::ST_SETTLE: begin
        if (sj == '0 || !(nd[sjm_i] > nd[sj_i])) begin
          state_next = knn_pkg::ST_ROW_START;
        end
      end
      knn_pkg::ST_VOTE_CLEAR: state_next = knn_pkg::ST_VOTE_TALLY;
      knn_pkg::ST_VOTE_TALLY: begin
        if (vi >= nearest_filled) begin
          state_next = knn_pkg::ST_VOTE_PICK;
        end
      end
      knn_pkg::ST_VOTE_PICK: begin
        if (32'(vc) == NumClasses - 1) begin
          state_next = knn_pkg::ST_EMIT;
        end
      end
      knn_pkg::ST_EMIT: begin
        if (!out_full) begin
          state_next = knn_pkg::ST_LOAD;
        end
      end
      default: state_next = knn_pkg::ST_LOAD;
    endcase
  end

  // State register and control counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= knn_pkg::ST_LOAD;
      stored_rows    <= '0;
      pixel_position <= '0;
      nearest_filled <= '0;
      neighbor_count <= knn_pkg::NeighborCountReset;
      weighted_vote  <= 1'b0;
      row_length     <= knn_pkg::RowLengthReset;
      out_full       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          knn_pkg::RegNeighborCount: neighbor_count <= cfg_data[knn_pkg::KW-1:0];
          knn_pkg::RegWeightedVote:  weighted_vote  <= cfg_data[0];
          knn_pkg::RegRowLength:     row_length     <= cfg_data[knn_pkg::LenW-1:0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        pixel_position <= last_pix ? '0 : pixel_position + PosW'(1);
        if (last_pix && !req_type && store_ok) begin
          stored_rows <= stored_rows + CntW'(1);
        end
        if (last_pix && req_type) begin
          nearest_filled <= '0;
        end
      end
      if (state == knn_pkg::ST_INSERT && nearest_filled < eff_k) begin
        nearest_filled <= nearest_filled + FillW'(1);
      end
      if (state == knn_pkg::ST_EMIT && !out_full) begin
        out_full <= 1'b1;
      end else if (out_full && !out_stall) begin
        out_full <= 1'b0;
      end
    end
  end

  // Datapath registers of the search and the vote.
  always_ff @(posedge clk) begin
    case (state)
      knn_pkg::ST_LOAD: begin
        row     <= '0;
        acc_pos <= '0;
      end
      knn_pkg::ST_ROW_START: begin
        acc_pos <= '0;
        sq_sum  <= '0;
        vi      <= '0;
      end
      knn_pkg::ST_ACCUM: begin
        acc_pos <= acc_pos + LenMW'(1);
        if (acc_pos != '0) begin
          sq_sum <= sq_sum + SumW'(sqd);
        end
      end
      knn_pkg::ST_ACCUM_TAIL: begin
        rad       <= knn_pkg::RadW'(sq_sum + SumW'(sqd)) << 16;
        root      <= '0;
        rem_r     <= '0;
        sq_step   <= '0;
        cur_label <= lab_rdata;
      end
      knn_pkg::ST_SQRT: begin
        rad     <= rad << 2;
        sq_step <= sq_step + 6'd1;
        if (rem_sh >= knn_pkg::RadW'(trial)) begin
          rem_r <= rem_sh - knn_pkg::RadW'(trial);
          root  <= {root[knn_pkg::RootW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          root  <= {root[knn_pkg::RootW-2:0], 1'b0};
        end
      end
      knn_pkg::ST_INSERT: begin
        row <= row + CntW'(1);
        if (nearest_filled < eff_k) begin
          nd[nearest_filled[KIdxW-1:0]] <= cur_dist;
          nl[nearest_filled[KIdxW-1:0]] <= cur_label;
          sj <= nearest_filled;
        end else if (nd[km_i] > cur_dist) begin
          // A full list only takes a row that beats its last entry.
          nd[km_i] <= cur_dist;
          nl[km_i] <= cur_label;
          sj <= km;
        end
      end
      knn_pkg::ST_SETTLE: begin
        if (sj != '0 && nd[sjm_i] > nd[sj_i]) begin
          nd[sjm_i] <= nd[sj_i];
          nl[sjm_i] <= nl[sj_i];
          nd[sj_i]  <= nd[sjm_i];
          nl[sj_i]  <= nl[sjm_i];
          sj        <= sjm;
        end
      end
      knn_pkg::ST_VOTE_CLEAR: begin
        for (int c = 0; c < NumClasses; c++) begin
          cnt[c]  <= '0;
          msum[c] <= '0;
        end
        vi    <= '0;
        vc    <= '0;
        best  <= '0;
        found <= 1'b0;
      end
      knn_pkg::ST_VOTE_TALLY: begin
        if (vi < nearest_filled) begin
          cnt[ClsW'(nl[vi_i])]  <= cnt[ClsW'(nl[vi_i])] + FillW'(1);
          msum[ClsW'(nl[vi_i])] <= msum[ClsW'(nl[vi_i])] + MsumW'(nd[vi_i]);
          vi <= vi + FillW'(1);
        end
      end
      knn_pkg::ST_VOTE_PICK: begin
        vc <= vc + ClsW'(1);
        if (weighted_vote) begin
          if (cnt[vc] != '0 && (!found || lhs > rhs)) begin
            best  <= vc;
            found <= 1'b1;
          end
        end else if (cnt[vc] > cnt[best]) begin
          best <= vc;
        end
      end
      knn_pkg::ST_EMIT: begin
        if (!out_full) begin
          result <= knn_pkg::LabelW'(best);
        end
      end
      default: ;
    endcase
  end

  // Saturate the finished root to the distance width.
  assign cur_dist = (root > knn_pkg::RootW'({knn_pkg::DistW{1'b1}})) ?
                    {knn_pkg::DistW{1'b1}} : root[knn_pkg::DistW-1:0];

  assign cfg_ready       = 1'b1;
  assign out_valid       = out_full;
  assign predicted_label = result;

`ifndef SYNTHESIS
  // The fill count never exceeds the list depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(nearest_filled) <= MaxK) else $error("fill count above list depth");
  // The stored row count never exceeds the store depth.
  a_rows_bound: assert property (@(posedge clk) disable iff (rst)
    32'(stored_rows) <= MaxTrain) else $error("stored rows above store depth");
  // A result held under stall stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(predicted_label))
    else $error("held result changed");
  // No input is taken while a search is running.
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    state != knn_pkg::ST_LOAD |-> in_stall) else $error("input taken mid search");
`endif

endmodule

// ===== src/knn_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module knn_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write, and registered read of the requested address (a read of the address being written returns the old data).
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
